FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the ramp sequencer.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// ante holds -> cons holds in the same cycle
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// ante holds -> cons holds in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/srps_pkg.sv
// Types and codes of the stepper ramp profile sequencer.
// No dependencies; used by every module of the block.
package srps_pkg;

    // item kinds
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_START   = 3'd1;
    localparam logic [2:0] KIND_STOP    = 3'd2;
    localparam logic [2:0] KIND_SETSTEP = 3'd3;
    localparam logic [2:0] KIND_LOAD_A  = 3'd4;
    localparam logic [2:0] KIND_LOAD_D  = 3'd5;

    // move phases
    localparam logic [2:0] PH_INIT  = 3'd0;
    localparam logic [2:0] PH_ACCEL = 3'd1;
    localparam logic [2:0] PH_CONST = 3'd2;
    localparam logic [2:0] PH_DECEL = 3'd3;
    localparam logic [2:0] PH_HOLD  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_ACCEL_SIZE = 3'd0;
    localparam logic [2:0] REG_DECEL_SIZE = 3'd1;
    localparam logic [2:0] REG_RUN_STEPS  = 3'd2;
    localparam logic [2:0] REG_USTEP_SH   = 3'd3;
    localparam logic [2:0] REG_DECEL_REV  = 3'd4;
    localparam logic [2:0] REG_CLK_PERIOD = 3'd5;

    localparam int CNT_W = 21;
    localparam int DIV_W = 32;

    typedef struct packed {
        logic [8:0]  accel_size;
        logic [8:0]  decel_size;
        logic [15:0] run_steps;
        logic [2:0]  microstep_shift;
        logic        decel_reversed;
        logic [15:0] tick_divisor;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  entry_index;
        logic [31:0] entry_value;
        logic [15:0] new_steps;
    } in_item_t;

    typedef struct packed {
        logic        period_load;
        logic [31:0] period_ticks;
        logic        running;
        logic [2:0]  phase;
        logic [19:0] steps_done;
        logic        finished;
        logic        request_error;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_start;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic load_pending;
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/srps_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
// Depends on srps_pkg.
module srps_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);

    localparam int CW = $clog2(srps_pkg::DIV_W);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   rem_reg, rem_next;
    logic [31:0]   quo_reg, quo_next;
    logic [15:0]   dvs_reg, dvs_next;
    logic [16:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[31]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(srps_pkg::DIV_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = 16'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/srps_dpath.sv
// Datapath: move state, ramp tables, tick divider and the output register.
// Depends on srps_pkg and srps_div; driven by srps_ctrl commands.
module srps_dpath #(
    parameter int RAMP_DEPTH = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  srps_pkg::cfg_t        cfg,
    input  srps_pkg::in_item_t    s_data,
    input  srps_pkg::ctrl_cmd_t   cmd,
    output srps_pkg::dp_status_t  stat,
    output srps_pkg::out_item_t   m_data,
    output logic                  m_valid,
    input  logic                  m_ready
);

    localparam int MEM_DEPTH = (RAMP_DEPTH < 256) ? RAMP_DEPTH : 256;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [12:0] DEPTH_L = 13'(RAMP_DEPTH);
    localparam logic [8:0]  TOP_L   = 9'(MEM_DEPTH);
    localparam int CW = srps_pkg::CNT_W;

    // move state
    logic [2:0]    phase_reg, phase_next;
    logic          run_reg, run_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] sc_reg, sc_next;
    logic [7:0]    pos_reg, pos_next;
    logic [CW-1:0] csl_reg, csl_next;

    srps_pkg::in_item_t  item_reg;
    srps_pkg::out_item_t res_reg, res_next;
    srps_pkg::out_item_t out_reg, out_next;
    logic                mv_reg;

    logic [31:0] acc_mem [MEM_DEPTH];
    logic [31:0] dec_mem [MEM_DEPTH];
    logic [31:0] acc_rdata, dec_rdata;

    logic          rd_en, rd_dec, rd_zero;
    logic [7:0]    rd_pos;
    logic          rd_dec_reg, rd_zero_reg;
    logic          wr_in_range;

    logic [8:0]    eff_acc, eff_dec;
    logic [2:0]    eff_sh;
    logic [15:0]   eff_clk;
    logic [CW-1:0] rem_dec, total, ramps, s_val, d_ext;
    logic [7:0]    dec_pos;

    logic          div_busy;
    logic [31:0]   div_q, div_dividend;

    always_comb begin
        eff_acc = (cfg.accel_size < 9'd2) ? 9'd2 :
                  (cfg.accel_size > TOP_L) ? TOP_L : cfg.accel_size;
        eff_dec = (cfg.decel_size < 9'd2) ? 9'd2 :
                  (cfg.decel_size > TOP_L) ? TOP_L : cfg.decel_size;
        eff_sh  = (cfg.microstep_shift > 3'd4) ? 3'd4 : cfg.microstep_shift;
        eff_clk = (cfg.tick_divisor == '0) ? 16'd1 : cfg.tick_divisor;
    end

    always_comb begin
        phase_next = phase_reg;
        run_next   = run_reg;
        rem_next   = rem_reg;
        sc_next    = sc_reg;
        pos_next   = pos_reg;
        csl_next   = csl_reg;
        res_next   = '0;
        rd_en      = 1'b0;
        rd_dec     = 1'b0;
        rd_pos     = '0;
        rem_dec    = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
        dec_pos    = cfg.decel_reversed ? 8'(eff_dec - 9'd1) : 8'd0;
        total      = CW'({5'b0, cfg.run_steps} << eff_sh);
        ramps      = CW'(eff_acc) + CW'(eff_dec);
        s_val      = CW'({5'b0, item_reg.new_steps} << eff_sh);
        d_ext      = CW'(eff_dec);

        case (item_reg.kind)
            srps_pkg::KIND_TICK: begin
                if (run_reg) begin
                    case (phase_reg)
                        srps_pkg::PH_ACCEL: begin
                            sc_next  = sc_reg + 1'b1;
                            rem_next = rem_dec;
                            pos_next = pos_reg + 1'b1;
                            rd_en    = 1'b1;
                            rd_pos   = pos_next;
                            res_next.period_load = 1'b1;
                            if (rem_dec <= CW'(1)) begin
                                if (csl_reg == '0) begin
                                    phase_next = srps_pkg::PH_DECEL;
                                    rem_next   = d_ext;
                                    pos_next   = dec_pos;
                                end else begin
                                    phase_next = srps_pkg::PH_CONST;
                                    rem_next   = csl_reg + 1'b1;
                                end
                            end
                        end
                        srps_pkg::PH_CONST: begin
                            sc_next  = sc_reg + 1'b1;
                            rem_next = rem_dec;
                            if (rem_dec <= CW'(1)) begin
                                phase_next = srps_pkg::PH_DECEL;
                                rem_next   = d_ext;
                                pos_next   = dec_pos;
                            end
                        end
                        srps_pkg::PH_DECEL: begin
                            sc_next  = sc_reg + 1'b1;
                            rem_next = rem_dec;
                            pos_next = cfg.decel_reversed ? pos_reg - 1'b1 : pos_reg + 1'b1;
                            rd_en    = 1'b1;
                            rd_dec   = 1'b1;
                            rd_pos   = pos_next;
                            res_next.period_load = 1'b1;
                            if (rem_dec <= CW'(1)) begin
                                phase_next = srps_pkg::PH_HOLD;
                            end
                        end
                        default: begin
                            // hold tick ends the move
                            phase_next = srps_pkg::PH_INIT;
                            run_next   = 1'b0;
                            res_next.finished = 1'b1;
                        end
                    endcase
                end
            end
            srps_pkg::KIND_START: begin
                csl_next   = (total > ramps) ? total - ramps : '0;
                pos_next   = '0;
                rem_next   = CW'(eff_acc);
                sc_next    = '0;
                rd_en      = 1'b1;
                rd_pos     = '0;
                phase_next = srps_pkg::PH_ACCEL;
                run_next   = 1'b1;
                res_next.period_load = 1'b1;
            end
            srps_pkg::KIND_STOP: begin
                if (run_reg && (phase_reg inside {srps_pkg::PH_INIT, srps_pkg::PH_ACCEL,
                                                  srps_pkg::PH_CONST})) begin
                    phase_next = srps_pkg::PH_DECEL;
                    rem_next   = d_ext;
                    pos_next   = dec_pos;
                end
            end
            srps_pkg::KIND_SETSTEP: begin
                if (!run_reg || phase_reg != srps_pkg::PH_CONST) begin
                    res_next.request_error = 1'b1;
                end else if (s_val > d_ext) begin
                    csl_next = s_val - d_ext;
                    rem_next = s_val - d_ext;
                end else begin
                    phase_next = srps_pkg::PH_DECEL;
                    rem_next   = d_ext;
                    pos_next   = dec_pos;
                end
            end
            default: begin
                // table loads and unused kinds leave the move alone
            end
        endcase

        rd_zero = ({5'b0, rd_pos} >= DEPTH_L);
        res_next.running    = run_next;
        res_next.phase      = phase_next;
        res_next.steps_done = 20'(sc_next >> eff_sh);
    end

    assign wr_in_range = ({5'b0, item_reg.entry_index} < DEPTH_L);

    always_comb begin
        out_next              = res_reg;
        out_next.period_ticks = res_reg.period_load ? div_q : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && item_reg.kind == srps_pkg::KIND_LOAD_A && wr_in_range) begin
            acc_mem[item_reg.entry_index[AW-1:0]] <= item_reg.entry_value;
        end
        if (cmd.exec && rd_en && !rd_dec) begin
            acc_rdata <= acc_mem[rd_pos[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && item_reg.kind == srps_pkg::KIND_LOAD_D && wr_in_range) begin
            dec_mem[item_reg.entry_index[AW-1:0]] <= item_reg.entry_value;
        end
        if (cmd.exec && rd_en && rd_dec) begin
            dec_rdata <= dec_mem[rd_pos[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= srps_pkg::PH_INIT;
            run_reg   <= 1'b0;
            rem_reg   <= '0;
            sc_reg    <= '0;
            pos_reg   <= '0;
            csl_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (cmd.exec) begin
                phase_reg <= phase_next;
                run_reg   <= run_next;
                rem_reg   <= rem_next;
                sc_reg    <= sc_next;
                pos_reg   <= pos_next;
                csl_reg   <= csl_next;
            end
            if (cmd.out_load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.exec) begin
            res_reg     <= res_next;
            rd_dec_reg  <= rd_dec;
            rd_zero_reg <= rd_zero;
        end
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    // entries past the table depth read as zero
    assign div_dividend = rd_zero_reg ? 32'd0 : (rd_dec_reg ? dec_rdata : acc_rdata);

    srps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (eff_clk),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign stat.load_pending = res_reg.period_load;
    assign stat.div_busy     = div_busy;
    assign stat.out_free     = !mv_reg || m_ready;

    assign m_data  = out_reg;
    assign m_valid = mv_reg;

endmodule

FILE: hw/rtl/srps_ctrl.sv
// Controller: sequences capture, state update, division (for items that issue a period) and writeback per item.
// Depends on srps_pkg; commands srps_dpath.
module srps_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output srps_pkg::ctrl_cmd_t   cmd,
    input  srps_pkg::dp_status_t  stat
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_WB   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // table data is registered now; start the tick conversion if a period is pending
                if (stat.load_pending) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_DIV: begin
                if (!stat.div_busy) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

FILE: hw/rtl/stepper_ramp_profile_sequencer.sv
// Stepper ramp profile sequencer: one result per accepted item.
// Items that issue no period pass capture, state update and writeback; items that issue one
// also read the table and run the bit-serial divider (ST_LOAD, ST_DIV) before writeback.
// A new item is taken only once the last result is in the output register; the divider and m_ready hold it.
// Reset (aresetn low, synchronous): config back to defaults, move idle, tables keep contents.
// Depends on srps_pkg, srps_ctrl, srps_dpath, srps_div and assert_macros.svh.
`include "assert_macros.svh"
module stepper_ramp_profile_sequencer #(
    parameter int RAMP_DEPTH = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  srps_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output srps_pkg::out_item_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    srps_pkg::cfg_t       cfg_reg;
    srps_pkg::ctrl_cmd_t  cmd;
    srps_pkg::dp_status_t stat;
    logic                 wr_en;
    logic [2:0]           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_size      <= 9'd2;
            cfg_reg.decel_size      <= 9'd2;
            cfg_reg.run_steps       <= 16'd0;
            cfg_reg.microstep_shift <= 3'd0;
            cfg_reg.decel_reversed  <= 1'b0;
            cfg_reg.tick_divisor    <= 16'd1;
        end else if (wr_en) begin
            case (reg_idx)
                srps_pkg::REG_ACCEL_SIZE: cfg_reg.accel_size      <= pwdata[8:0];
                srps_pkg::REG_DECEL_SIZE: cfg_reg.decel_size      <= pwdata[8:0];
                srps_pkg::REG_RUN_STEPS:  cfg_reg.run_steps       <= pwdata[15:0];
                srps_pkg::REG_USTEP_SH:   cfg_reg.microstep_shift <= pwdata[2:0];
                srps_pkg::REG_DECEL_REV:  cfg_reg.decel_reversed  <= pwdata[0];
                srps_pkg::REG_CLK_PERIOD: cfg_reg.tick_divisor    <= pwdata[15:0];
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            srps_pkg::REG_ACCEL_SIZE: prdata = {23'b0, cfg_reg.accel_size};
            srps_pkg::REG_DECEL_SIZE: prdata = {23'b0, cfg_reg.decel_size};
            srps_pkg::REG_RUN_STEPS:  prdata = {16'b0, cfg_reg.run_steps};
            srps_pkg::REG_USTEP_SH:   prdata = {29'b0, cfg_reg.microstep_shift};
            srps_pkg::REG_DECEL_REV:  prdata = {31'b0, cfg_reg.decel_reversed};
            srps_pkg::REG_CLK_PERIOD: prdata = {16'b0, cfg_reg.tick_divisor};
            default:                  prdata = 32'd0;
        endcase
    end

    srps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    srps_dpath #(
        .RAMP_DEPTH (RAMP_DEPTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

    `ASSERT_IMPL(a_idle_div_quiet, aclk, aresetn, s_ready, !stat.div_busy)
    `ASSERT_NEXT(a_one_item_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ASSERT_IMPL(a_wb_slot_free, aclk, aresetn, cmd.out_load, !m_valid || m_ready)
    `ASSERT_NEXT(a_wb_sets_valid, aclk, aresetn, cmd.out_load, m_valid)

endmodule
